// ===== hdl/p2a_pkg.sv =====
// p2a_pkg: shared types and constants for the pcm16 to a-law packetizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package p2a_pkg;

    // one raw byte of the little-endian pcm stream
    typedef struct packed {
        logic [7:0] pcm_byte;
        logic       discontinuity;
    } t_in_item;

    // one encoded byte with its packet framing
    typedef struct packed {
        logic [7:0]  alaw_byte;
        logic [7:0]  payload_index;
        logic        last_of_packet;
        logic [31:0] packet_sequence;
    } t_out_item;

    // even-bit inversion masks, sign folded in
    localparam logic [7:0] ALAW_MASK_NEG = 8'h55;
    localparam logic [7:0] ALAW_MASK_POS = 8'hD5;

    localparam logic [31:0] SEQ_FIRST = 32'd1;
    localparam logic [31:0] SEQ_MAX   = 32'hFFFF_FFFF;

endpackage

// ===== hdl/p2a_alaw_enc.sv =====
// p2a_alaw_enc: combinational g.711 a-law segment encoder, 16-bit sample in
// depends on p2a_pkg for the inversion masks
`timescale 1ns / 1ps

module p2a_alaw_enc
    import p2a_pkg::*;
(
    input  logic [15:0] i_sample,
    output logic [7:0]  o_code
);

    logic [7:0]  mask;
    logic [15:0] folded;
    logic [11:0] mag;
    logic [2:0]  seg;
    logic [3:0]  mant;

    always_comb begin
        if (i_sample[15]) begin
            mask   = ALAW_MASK_NEG;
            folded = ~i_sample;
        end else begin
            mask   = ALAW_MASK_POS;
            folded = i_sample;
        end
        // magnitude after dropping three lsbs never exceeds 4095
        mag = folded[14:3];
    end

    // segment is the position of the leading one above bit 4
    always_comb begin
        if (mag[11])      seg = 3'd7;
        else if (mag[10]) seg = 3'd6;
        else if (mag[9])  seg = 3'd5;
        else if (mag[8])  seg = 3'd4;
        else if (mag[7])  seg = 3'd3;
        else if (mag[6])  seg = 3'd2;
        else if (mag[5])  seg = 3'd1;
        else              seg = 3'd0;
    end

    always_comb begin
        case (seg)
            3'd0, 3'd1: mant = mag[4:1];
            3'd2:       mant = mag[5:2];
            3'd3:       mant = mag[6:3];
            3'd4:       mant = mag[7:4];
            3'd5:       mant = mag[8:5];
            3'd6:       mant = mag[9:6];
            3'd7:       mant = mag[10:7];
            default:    mant = mag[4:1];
        endcase
    end

    assign o_code = {1'b0, seg, mant} ^ mask;

endmodule

// ===== hdl/pcm16_to_alaw_packetizer_top.sv =====
// pcm16_to_alaw_packetizer_top: byte input register, packet framing, result register
// depends on p2a_pkg and p2a_alaw_enc
`timescale 1ns / 1ps

// Usage
//   Input channel: one byte of little-endian signed 16-bit pcm per request on
//   i_in_data, qualified by i_in_valid, held off by o_in_stall. A set
//   discontinuity bit drops the partial payload and any held low byte before
//   that byte is taken, so the byte starts a new sample.
//   Output channel: one a-law byte per completed sample on o_out_data, with
//   its payload position; the byte that fills PAYLOAD_BYTES is flagged last
//   and carries the packet sequence number (1, 2, ... wrapping past 0 to 1).
//   Low bytes produce no result.
//   A high byte accepted into the input register moves its result into the
//   result register once that is free. Throughput: one byte per cycle while
//   the receiver does not stall, set by the single combinational pass between
//   the input register and the result register.
//   When the receiver stalls, the result register holds; low bytes keep
//   flowing, and the input register fills and stalls the sender only once a
//   high byte has to wait for the result register.
//   Reset (synchronous, active low) empties both registers, clears the fill
//   count, the held low byte and the sequence counter.
module pcm16_to_alaw_packetizer_top
    import p2a_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int FW = $clog2(PAYLOAD_BYTES + 1);

    logic           r_in_valid;
    t_in_item       r_in_data;
    logic [FW-1:0]  r_fill;
    logic [FW-1:0]  n_fill;
    logic [7:0]     r_low;
    logic [7:0]     n_low;
    logic           r_low_valid;
    logic           n_low_valid;
    logic [31:0]    r_seq;
    logic [31:0]    n_seq;
    logic           r_out_valid;
    t_out_item      r_out_data;
    t_out_item      n_out_data;

    logic           have_low;
    logic           makes_result;
    logic           out_free;
    logic           advance;
    logic [FW-1:0]  fill_base;
    logic [FW-1:0]  fill_inc;
    logic           fill_done;
    logic [FW+7:0]  index_wide;
    logic [31:0]    seq_inc;
    logic [7:0]     code;

    p2a_alaw_enc u_enc (
        .i_sample (({r_in_data.pcm_byte, r_low})),
        .o_code   (code)
    );

    assign have_low     = r_low_valid && !r_in_data.discontinuity;
    assign makes_result = r_in_valid && have_low;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign advance      = r_in_valid && (out_free || !have_low);
    assign o_in_stall   = r_in_valid && !advance;

    assign fill_base  = r_in_data.discontinuity ? '0 : r_fill;
    assign fill_inc   = fill_base + FW'(1);
    assign fill_done  = (fill_inc == FW'(PAYLOAD_BYTES));
    assign index_wide = {8'b0, fill_base};
    assign seq_inc    = (r_seq == SEQ_MAX) ? SEQ_FIRST : r_seq + 32'd1;

    always_comb begin
        n_fill       = fill_base;
        n_low        = r_low;
        n_low_valid  = r_low_valid;
        n_seq        = r_seq;
        n_out_data   = r_out_data;
        if (advance) begin
            if (have_low) begin
                n_low_valid                = 1'b0;
                n_out_data.alaw_byte       = code;
                n_out_data.payload_index   = index_wide[7:0];
                n_out_data.last_of_packet  = fill_done;
                n_out_data.packet_sequence = fill_done ? seq_inc : 32'd0;
                if (fill_done) begin
                    n_fill = '0;
                    n_seq  = seq_inc;
                end else begin
                    n_fill = fill_inc;
                end
            end else begin
                n_low       = r_in_data.pcm_byte;
                n_low_valid = 1'b1;
            end
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_low       <= '0;
            r_low_valid <= 1'b0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            r_fill      <= n_fill;
            r_low       <= n_low;
            r_low_valid <= n_low_valid;
            r_seq       <= n_seq;
            if (makes_result && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_data <= i_in_data;
        end
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_last_has_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.last_of_packet |-> r_out_data.packet_sequence != 32'd0)
        else $error("last result without sequence number");

    a_mid_no_seq : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data.last_of_packet |-> r_out_data.packet_sequence == 32'd0)
        else $error("sequence number on a result that is not last");

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FW'(PAYLOAD_BYTES))
        else $error("fill count reached payload size");

    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_seq_steps : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq != $past(r_seq) && $past(i_rst_n) |-> r_out_valid && r_out_data.last_of_packet)
        else $error("sequence counter moved without a packet");

endmodule

// ===== sim/pcm16_to_alaw_packetizer_top_test.sv =====
// pcm16_to_alaw_packetizer_top_test: self-checking bench for the pcm16 to a-law packetizer
// depends on p2a_pkg and pcm16_to_alaw_packetizer_top; predicts a-law codes and packet framing
`timescale 1ns / 1ps

module pcm16_to_alaw_packetizer_top_test;
    import p2a_pkg::*;

    localparam int          PAYLOAD_BYTES = 256;
    localparam int          RANDOM_BYTES  = 1600;
    localparam int unsigned CYCLE_LIMIT   = 800_000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          TAIL_CYCLES   = 20;

    typedef struct {
        t_in_item item;
        bit       drain;
    } t_pend;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_pend     pending[$];
    t_pend     next_req;
    t_out_item alaw_expected[$];

    // predictor state
    int unsigned fill_cnt = 0;
    logic [7:0]  low_byte = '0;
    bit          low_held = 1'b0;
    logic [31:0] seq_num = '0;

    int unsigned cycle = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          n_sent = 0;
    int          n_disc = 0;
    int          n_results = 0;
    int          n_packets = 0;
    int          n_errors = 0;
    logic        quiet;

    // stretches with no random gaps on the sender side and no random stalls on the receiver side
    assign quiet = ((cycle / 2500) % 4) == 1;

    pcm16_to_alaw_packetizer_top #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic logic [7:0] alaw_of(input logic [15:0] sample);
        logic [7:0]  mask;
        int unsigned mag;
        int unsigned seg;
        if (sample[15]) begin
            mask = ALAW_MASK_NEG;
            mag  = {16'b0, ~sample};
        end else begin
            mask = ALAW_MASK_POS;
            mag  = {16'b0, sample};
        end
        mag = mag >> 3;
        seg = 0;
        while (seg < 8 && mag > ((32'h20 << seg) - 1))
            seg++;
        if (seg >= 8)
            return 8'h7F ^ mask;
        return {4'(seg), 4'(seg < 2 ? mag >> 1 : mag >> seg)} ^ mask;
    endfunction

    task automatic take_byte(input t_in_item it);
        t_out_item res;
        if (it.discontinuity) begin
            fill_cnt = 0;
            low_held = 1'b0;
        end
        if (!low_held) begin
            low_byte = it.pcm_byte;
            low_held = 1'b1;
        end else begin
            low_held = 1'b0;
            res.alaw_byte       = alaw_of({it.pcm_byte, low_byte});
            res.payload_index   = fill_cnt[7:0];
            res.last_of_packet  = 1'b0;
            res.packet_sequence = '0;
            fill_cnt++;
            if (fill_cnt >= PAYLOAD_BYTES) begin
                seq_num = (seq_num == SEQ_MAX) ? SEQ_FIRST : seq_num + 1;
                res.last_of_packet  = 1'b1;
                res.packet_sequence = seq_num;
                fill_cnt = 0;
            end
            alaw_expected.push_back(res);
        end
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle, what, got, want);
        n_errors++;
    endtask

    // mostly short, a few long
    function automatic int rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] rand_sample();
        logic [15:0] corners[4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        int unsigned r;
        logic [15:0] s;
        r = $urandom_range(0, 99);
        if (r < 35)
            s = 16'($urandom);
        else if (r < 70)
            s = 16'($urandom_range(0, 32'h7FFF) >> $urandom_range(0, 14));
        else if (r < 85)
            s = 16'($urandom_range(0, 300));
        else
            s = corners[$urandom_range(0, 3)];
        if (r >= 35 && r < 85 && $urandom_range(0, 1))
            s = ~s;
        return s;
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input bit disc, input bit drain);
        t_pend p;
        p.item.pcm_byte      = b;
        p.item.discontinuity = disc;
        p.drain              = drain;
        pending.push_back(p);
    endfunction

    function automatic void queue_sample(input logic [15:0] s, input bit disc, input bit drain);
        queue_byte(s[7:0], disc, drain);
        queue_byte(s[15:8], 1'b0, 1'b0);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                take_byte(in_data);
                n_sent++;
                if (in_data.discontinuity)
                    n_disc++;
            end
            if (in_valid && o_in_stall) begin
                // stalled: hold valid and payload
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && alaw_expected.size() > 0)) begin
                next_req = pending.pop_front();
                in_valid <= 1'b1;
                in_data  <= next_req.item;
                gap_left <= quiet ? 0 : rand_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (!hold_done && n_results >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                stall_left = rand_gap();
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (o_out_data.last_of_packet)
                n_packets++;
            if (alaw_expected.size() == 0) begin
                report("result with nothing expected, a-law", 32'(o_out_data.alaw_byte), '0);
            end else begin
                want = alaw_expected.pop_front();
                if (o_out_data.alaw_byte !== want.alaw_byte)
                    report("alaw_byte", 32'(o_out_data.alaw_byte), 32'(want.alaw_byte));
                if (o_out_data.payload_index !== want.payload_index)
                    report("payload_index", 32'(o_out_data.payload_index),
                           32'(want.payload_index));
                if (o_out_data.last_of_packet !== want.last_of_packet)
                    report("last_of_packet", 32'(o_out_data.last_of_packet),
                           32'(want.last_of_packet));
                if (o_out_data.packet_sequence !== want.packet_sequence)
                    report("packet_sequence", o_out_data.packet_sequence,
                           want.packet_sequence);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle);
            $display("pcm16_to_alaw_packetizer_top_test failed");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        int          target;
        // directed: zero, full scale both signs, segment edges
        queue_sample(16'h0000, 1'b1, 1'b0);
        queue_sample(16'h7FFF, 1'b0, 1'b0);
        queue_sample(16'h8000, 1'b0, 1'b0);
        queue_sample(16'hFFFF, 1'b0, 1'b0);
        queue_sample(16'h00FF, 1'b0, 1'b0);
        queue_sample(16'h0100, 1'b0, 1'b0);
        queue_sample(16'hFEFF, 1'b0, 1'b0);
        queue_sample(16'hF000, 1'b0, 1'b0);
        // discontinuity drops a held low byte; the flagged byte becomes the new low byte
        queue_byte(8'h12, 1'b0, 1'b0);
        queue_byte(8'h34, 1'b1, 1'b0);
        queue_byte(8'h56, 1'b0, 1'b0);
        // discontinuity on a low byte restarts the partial payload at index 0
        queue_sample(16'h1234, 1'b1, 1'b0);
        queue_sample(16'hABCD, 1'b0, 1'b0);

        // random: mostly aligned samples, some stray bytes and discontinuities
        target = pending.size() + RANDOM_BYTES;
        queue_sample(rand_sample(), 1'b0, 1'b1);
        while (pending.size() < target) begin
            r = $urandom_range(0, 999);
            if (r < 6)
                queue_byte(8'($urandom), 1'b1, 1'b0);
            else if (r < 10)
                queue_byte(8'($urandom), 1'b0, 1'b0);
            else if (r < 16)
                queue_sample(rand_sample(), 1'b1, 1'b0);
            else if (r < 20)
                queue_sample(rand_sample(), 1'b0, 1'b1);
            else
                queue_sample(rand_sample(), 1'b0, 1'b0);
        end

        @(posedge i_clk);
        while (!i_rst_n || pending.size() > 0 || in_valid)
            @(posedge i_clk);
        while (alaw_expected.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d pcm bytes (%0d with discontinuity), checked %0d a-law results",
                 n_sent, n_disc, n_results);
        $display("saw %0d full packets, %0d mismatches", n_packets, n_errors);
        if (n_errors == 0) begin
            $display("pcm16_to_alaw_packetizer_top_test passed");
        end else begin
            $display("pcm16_to_alaw_packetizer_top_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/p2a_pkg.sv
hdl/p2a_alaw_enc.sv
hdl/pcm16_to_alaw_packetizer_top.sv
sim/pcm16_to_alaw_packetizer_top_test.sv
